// ----- sv/triangle_unit_normal_top_macros.svh -----
// ----------------------------------------------------------------------------
// triangle unit normal assertion macros
// shared concurrent checks, sampled on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_TOP_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_MACROS_SVH

// same-cycle implication
`define TUN_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TUN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/tun_pkg.sv -----
// ----------------------------------------------------------------------------
// tun_pkg
// beat types and fixed widths of the triangle unit normal pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

   localparam int COORD_W     = 24;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int ABS_W       = CROSS_W;
   localparam int LO_W        = (ABS_W + 1) / 2;
   localparam int HI_W        = ABS_W - LO_W;
   localparam int SQ_W        = 2 * ABS_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int OUT_W       = 16;
   localparam int OUT_MAX     = 32767;
   localparam int OUT_MIN_MAG = 32768;

   typedef struct packed {
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
      logic signed [COORD_W-1:0] v3_x;
      logic signed [COORD_W-1:0] v3_y;
      logic signed [COORD_W-1:0] v3_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      logic                    degenerate;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       degenerate;
      logic [2:0] neg;
   } ctl_type;

endpackage

`default_nettype wire

// ----- sv/tun_front.sv -----
// ----------------------------------------------------------------------------
// tun_front
// edge vectors, partial products and cross product, three register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_front import tun_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  req_type                   in_req,
   output logic                      out_valid,
   output logic signed [CROSS_W-1:0] out_cx,
   output logic signed [CROSS_W-1:0] out_cy,
   output logic signed [CROSS_W-1:0] out_cz
);

   logic [2:0]               vld_ff;
   logic signed [DIFF_W-1:0] dif_ff [6];
   logic signed [DIFF_W-1:0] dif_in [6];
   logic signed [PROD_W-1:0] pro_ff [6];
   logic signed [PROD_W-1:0] pro_in [6];
   logic signed [CROSS_W-1:0] crs_ff [3];
   logic signed [CROSS_W-1:0] crs_in [3];

   // a = v2 - v1, b = v3 - v2
   always_comb begin
      dif_in[0] = DIFF_W'(in_req.v2_x) - DIFF_W'(in_req.v1_x);
      dif_in[1] = DIFF_W'(in_req.v2_y) - DIFF_W'(in_req.v1_y);
      dif_in[2] = DIFF_W'(in_req.v2_z) - DIFF_W'(in_req.v1_z);
      dif_in[3] = DIFF_W'(in_req.v3_x) - DIFF_W'(in_req.v2_x);
      dif_in[4] = DIFF_W'(in_req.v3_y) - DIFF_W'(in_req.v2_y);
      dif_in[5] = DIFF_W'(in_req.v3_z) - DIFF_W'(in_req.v2_z);
   end

   always_comb begin
      pro_in[0] = dif_ff[1] * dif_ff[5];
      pro_in[1] = dif_ff[2] * dif_ff[4];
      pro_in[2] = dif_ff[2] * dif_ff[3];
      pro_in[3] = dif_ff[0] * dif_ff[5];
      pro_in[4] = dif_ff[0] * dif_ff[4];
      pro_in[5] = dif_ff[1] * dif_ff[3];
   end

   always_comb begin
      crs_in[0] = CROSS_W'(pro_ff[0]) - CROSS_W'(pro_ff[1]);
      crs_in[1] = CROSS_W'(pro_ff[2]) - CROSS_W'(pro_ff[3]);
      crs_in[2] = CROSS_W'(pro_ff[4]) - CROSS_W'(pro_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      dif_ff <= dif_in;
      pro_ff <= pro_in;
      crs_ff <= crs_in;
   end

   assign out_valid = vld_ff[2];
   assign out_cx    = crs_ff[0];
   assign out_cy    = crs_ff[1];
   assign out_cz    = crs_ff[2];

endmodule

`default_nettype wire

// ----- sv/tun_square.sv -----
// ----------------------------------------------------------------------------
// tun_square
// squared length of the cross product and start values of the root search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_square import tun_pkg::*; #(
   parameter int FRAC_BITS = 15,
   parameter int REM_W     = 144
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [CROSS_W-1:0] in_c [3],
   output ctl_type                   out_ctl,
   output logic [SUM_W-1:0]          out_s,
   output logic signed [REM_W-1:0]   out_rem [3],
   output logic signed [REM_W-1:0]   out_p [3]
);

   logic [3:0]             vld_ff;
   logic [2:0]             neg_ff [4];
   logic                   deg_ff [2];
   logic                   deg_in;
   logic [ABS_W-1:0]       mag [3];
   logic [2*LO_W-1:0]      pll_ff [3];
   logic [LO_W+HI_W-1:0]   plh_ff [3];
   logic [2*HI_W-1:0]      phh_ff [3];
   logic [SQ_W-1:0]        sq_ff [3];
   logic [SQ_W-1:0]        sq_in [3];
   logic [SUM_W-1:0]       s_ff [2];
   logic [SUM_W-1:0]       s_in;
   logic signed [REM_W-1:0] r_ff [3];
   logic signed [REM_W-1:0] rem_ff [3];
   logic signed [REM_W-1:0] p_ff [3];
   logic [2:0]             neg_in;

   // magnitudes split in halves for narrow multipliers
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_c[i][CROSS_W-1];
         mag[i]    = ABS_W'(in_c[i][CROSS_W-1] ? -in_c[i] : in_c[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (SQ_W'(phh_ff[i]) << (2 * LO_W))
                  + (SQ_W'(plh_ff[i]) << (LO_W + 1))
                  + SQ_W'(pll_ff[i]);
      end
   end

   assign s_in   = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   assign deg_in = (sq_ff[0] | sq_ff[1] | sq_ff[2]) == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pll_ff[i] <= mag[i][LO_W-1:0] * mag[i][LO_W-1:0];
         plh_ff[i] <= mag[i][LO_W-1:0] * mag[i][ABS_W-1:LO_W];
         phh_ff[i] <= mag[i][ABS_W-1:LO_W] * mag[i][ABS_W-1:LO_W];
         sq_ff[i]  <= sq_in[i];
         r_ff[i]   <= REM_W'(sq_ff[i]) << (2 * FRAC_BITS + 2);
         rem_ff[i] <= r_ff[i] - REM_W'(s_ff[0]);
         p_ff[i]   <= -REM_W'(s_ff[0]);
      end
      neg_ff[0] <= neg_in;
      neg_ff[1] <= neg_ff[0];
      neg_ff[2] <= neg_ff[1];
      neg_ff[3] <= neg_ff[2];
      s_ff[0]   <= s_in;
      s_ff[1]   <= s_ff[0];
      deg_ff[0] <= deg_in;
      deg_ff[1] <= deg_ff[0];
   end

   assign out_ctl.valid      = vld_ff[3];
   assign out_ctl.degenerate = deg_ff[1];
   assign out_ctl.neg        = neg_ff[3];
   assign out_s              = s_ff[1];
   assign out_rem            = rem_ff;
   assign out_p              = p_ff;

endmodule

`default_nettype wire

// ----- sv/tun_digit.sv -----
// ----------------------------------------------------------------------------
// tun_digit
// one quotient bit of the rounded normal for all three components
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_digit import tun_pkg::*; #(
   parameter int REM_W = 144,
   parameter int QW    = 16,
   parameter int K     = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctl_type                 in_ctl,
   input  logic [SUM_W-1:0]        in_s,
   input  logic signed [REM_W-1:0] in_rem [3],
   input  logic signed [REM_W-1:0] in_p [3],
   input  logic [QW-1:0]           in_q [3],
   output ctl_type                 out_ctl,
   output logic [SUM_W-1:0]        out_s,
   output logic signed [REM_W-1:0] out_rem [3],
   output logic signed [REM_W-1:0] out_p [3],
   output logic [QW-1:0]           out_q [3]
);

   ctl_type                 ctl_ff;
   logic [SUM_W-1:0]        s_ff;
   logic signed [REM_W-1:0] cost [3];
   logic [2:0]              take;
   logic signed [REM_W-1:0] rem_ff [3];
   logic signed [REM_W-1:0] rem_in [3];
   logic signed [REM_W-1:0] p_ff [3];
   logic signed [REM_W-1:0] p_in [3];
   logic [QW-1:0]           q_ff [3];
   logic [QW-1:0]           q_in [3];

   // trial u + 2^(K+1): cost = 2^(K+2) u s + 2^(2K+2) s
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cost[i]   = (in_p[i] <<< (K + 2)) + $signed(REM_W'(in_s) << (2 * K + 2));
         take[i]   = cost[i] <= in_rem[i];
         rem_in[i] = take[i] ? in_rem[i] - cost[i] : in_rem[i];
         p_in[i]   = take[i] ? in_p[i] + $signed(REM_W'(in_s) << (K + 1)) : in_p[i];
         q_in[i]   = in_q[i] | (QW'(take[i]) << K);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= in_s;
      rem_ff <= rem_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
   end

   assign out_ctl = ctl_ff;
   assign out_s   = s_ff;
   assign out_rem = rem_ff;
   assign out_p   = p_ff;
   assign out_q   = q_ff;

endmodule

`default_nettype wire

// ----- sv/triangle_unit_normal_top.sv -----
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// unit normal of one triangle per beat, rounded and saturated fixed point
//
// channel   ports                        handshake
// input     start, busy, req_data        start & !busy
// result    rsp_strobe, rsp_data         rsp_strobe, one cycle
//
// one triangle per cycle
// the latency is set by the root search, one quotient bit per stage
// busy stays low, the pipeline never holds off a beat
// synchronous reset clears the valid bits, payload stages are not reset
// results appear for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_unit_normal_top_macros.svh"

module triangle_unit_normal_top import tun_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = 15
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int QW    = NORMAL_FRAC_BITS + 1;
   localparam int REM_W = SUM_W + 2 * NORMAL_FRAC_BITS + 7;
   localparam int LAT   = QW + 8;
   localparam int CAP_W = (QW > OUT_W + 1) ? QW : OUT_W + 1;

   logic                      fr_valid;
   logic signed [CROSS_W-1:0] fr_c [3];
   ctl_type                   ch_ctl [QW+1];
   logic [SUM_W-1:0]          ch_s [QW+1];
   logic signed [REM_W-1:0]   ch_rem [QW+1][3];
   logic signed [REM_W-1:0]   ch_p [QW+1][3];
   logic [QW-1:0]             ch_q [QW+1][3];
   logic [CAP_W-1:0]          cap [3];
   logic [OUT_W-1:0]          nv [3];
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   assign busy = 1'b0;

   tun_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_req    (req_data),
      .out_valid (fr_valid),
      .out_cx    (fr_c[0]),
      .out_cy    (fr_c[1]),
      .out_cz    (fr_c[2])
   );

   tun_square #(
      .FRAC_BITS (NORMAL_FRAC_BITS),
      .REM_W     (REM_W)
   ) u_square (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_valid),
      .in_c     (fr_c),
      .out_ctl  (ch_ctl[0]),
      .out_s    (ch_s[0]),
      .out_rem  (ch_rem[0]),
      .out_p    (ch_p[0])
   );

   assign ch_q[0][0] = '0;
   assign ch_q[0][1] = '0;
   assign ch_q[0][2] = '0;

   for (genvar j = 0; j < QW; j++) begin : g_digit
      tun_digit #(
         .REM_W (REM_W),
         .QW    (QW),
         .K     (QW - 1 - j)
      ) u_digit (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (ch_ctl[j]),
         .in_s    (ch_s[j]),
         .in_rem  (ch_rem[j]),
         .in_p    (ch_p[j]),
         .in_q    (ch_q[j]),
         .out_ctl (ch_ctl[j+1]),
         .out_s   (ch_s[j+1]),
         .out_rem (ch_rem[j+1]),
         .out_p   (ch_p[j+1]),
         .out_q   (ch_q[j+1])
      );
   end

   // sign, saturation and degenerate override
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cap[i] = (CAP_W'(ch_q[QW][i]) > CAP_W'(OUT_MIN_MAG)) ?
                  CAP_W'(OUT_MIN_MAG) : CAP_W'(ch_q[QW][i]);
         if (ch_ctl[QW].degenerate) begin
            nv[i] = '0;
         end else if (ch_ctl[QW].neg[i]) begin
            nv[i] = OUT_W'(-cap[i]);
         end else if (cap[i] > CAP_W'(OUT_MAX)) begin
            nv[i] = OUT_W'(OUT_MAX);
         end else begin
            nv[i] = OUT_W'(cap[i]);
         end
      end
      rsp_in.normal_x   = nv[0];
      rsp_in.normal_y   = nv[1];
      rsp_in.normal_z   = nv[2];
      rsp_in.degenerate = ch_ctl[QW].degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ch_ctl[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `TUN_ASSERT_SAME(a_latency, rsp_strobe, $past(start && !busy, LAT), "result beat without input beat")
   `TUN_ASSERT_SAME(a_degen_zero, rsp_strobe && rsp_data.degenerate, rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0, "degenerate beat with nonzero normal")
   `TUN_ASSERT_SAME(a_normal_nonzero, rsp_strobe && !rsp_data.degenerate, rsp_data.normal_x != '0 || rsp_data.normal_y != '0 || rsp_data.normal_z != '0, "zero normal on a proper triangle")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the triangle unit normal pipeline against an exact software
// predictor: directed corner triangles, then random triangles of mixed shape,
// with random gaps between request beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import tun_pkg::*;

   class normal_scoreboard;
      rsp_type pending_normals[$];
      int      mismatches;

      function automatic logic signed [OUT_W-1:0] unit_component(
         longint signed c, logic [159:0] len_sq);
         logic [159:0] mag;
         logic [159:0] bound;
         logic [159:0] t;
         longint       lo;
         longint       hi;
         longint       mid;
         mag   = (c < 0) ? -c : c;
         bound = (mag * mag) << 32;
         lo    = 0;
         hi    = OUT_MIN_MAG;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 2 * mid - 1;
            if (t * t * len_sq <= bound) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         if (c < 0) begin
            lo = -lo;
         end else if (lo > OUT_MAX) begin
            lo = OUT_MAX;
         end
         return lo[OUT_W-1:0];
      endfunction

      function void note_triangle(req_type r);
         longint signed ax, ay, az, bx, by, bz, cx, cy, cz;
         logic [159:0]  len_sq;
         rsp_type       n;
         ax = longint'(r.v2_x) - longint'(r.v1_x);
         ay = longint'(r.v2_y) - longint'(r.v1_y);
         az = longint'(r.v2_z) - longint'(r.v1_z);
         bx = longint'(r.v3_x) - longint'(r.v2_x);
         by = longint'(r.v3_y) - longint'(r.v2_y);
         bz = longint'(r.v3_z) - longint'(r.v2_z);
         cx = ay * bz - az * by;
         cy = az * bx - ax * bz;
         cz = ax * by - ay * bx;
         len_sq = 160'(cx < 0 ? -cx : cx) * 160'(cx < 0 ? -cx : cx)
                + 160'(cy < 0 ? -cy : cy) * 160'(cy < 0 ? -cy : cy)
                + 160'(cz < 0 ? -cz : cz) * 160'(cz < 0 ? -cz : cz);
         if (len_sq == 0) begin
            n = '{normal_x: '0, normal_y: '0, normal_z: '0, degenerate: 1'b1};
         end else begin
            n.normal_x   = unit_component(cx, len_sq);
            n.normal_y   = unit_component(cy, len_sq);
            n.normal_z   = unit_component(cz, len_sq);
            n.degenerate = 1'b0;
         end
         pending_normals.push_back(n);
      endfunction

      function void check_normal(rsp_type got);
         rsp_type exp;
         if (pending_normals.size() == 0) begin
            $error("unexpected result beat %h", got);
            mismatches++;
            return;
         end
         exp = pending_normals.pop_front();
         if (got.normal_x !== exp.normal_x) begin
            $error("normal_x expected %0d actual %0d", exp.normal_x, got.normal_x);
            mismatches++;
         end
         if (got.normal_y !== exp.normal_y) begin
            $error("normal_y expected %0d actual %0d", exp.normal_y, got.normal_y);
            mismatches++;
         end
         if (got.normal_z !== exp.normal_z) begin
            $error("normal_z expected %0d actual %0d", exp.normal_z, got.normal_z);
            mismatches++;
         end
         if (got.degenerate !== exp.degenerate) begin
            $error("degenerate expected %0b actual %0b", exp.degenerate,
                   got.degenerate);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    beat_taken = 1'b0;
   int      cycle_count = 0;

   normal_scoreboard sb = new();

   triangle_unit_normal_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      beat_taken  <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         sb.note_triangle(req_data);
      end
      if (!reset && rsp_strobe) begin
         sb.check_normal(rsp_data);
      end
      if (cycle_count > 300000) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [COORD_W-1:0] rand_coord(int mode);
      case (mode)
         0: rand_coord = COORD_W'($urandom);
         1: rand_coord = COORD_W'($urandom_range(0, 2047) - 1024);
         default: rand_coord = ($urandom_range(0, 3) == 0) ? 24'h800000 : 24'h7fffff;
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_triangle(req_type r);
      int gap;
      start    = 1'b1;
      req_data = r;
      do @(negedge clock); while (!beat_taken);
      gap = $urandom_range(0, 9) < 6 ? 0 :
            ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(4, 40));
      if (gap > 0) begin
         start    = 1'b0;
         req_data = '0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_coords(int a, int b, int c, int d, int e, int f,
                              int g, int h, int i);
      req_type r;
      r = '{24'(a), 24'(b), 24'(c), 24'(d), 24'(e), 24'(f), 24'(g), 24'(h), 24'(i)};
      send_triangle(r);
   endtask

   initial begin
      req_type r;
      int      mode;
      int      k;
      int      s;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_coords(5, 5, 5, 5, 5, 5, 5, 5, 5);
      send_coords(0, 0, 0, 1, 1, 1, 2, 2, 2);
      send_coords(0, 0, 0, 1, 0, 0, 1, 1, 0);
      send_coords(0, 0, 0, 0, 1, 0, 1, 1, 0);
      send_coords(0, 0, 0, 0, 1, 0, 0, 1, 1);
      send_coords(0, 0, 0, 0, 0, 1, 0, 1, 1);
      send_coords(0, 0, 0, 0, 0, 1, 1, 0, 1);
      send_coords(0, 0, 0, 1, 0, 0, 1, 0, 1);
      send_coords(0, 0, 0, 1, 0, 0, 1, 1, 1);
      send_coords(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                  8388607, 8388607, -8388608);
      send_coords(8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
                  -8388608, -8388608, 8388607);
      send_coords(-8388608, 0, 8388607, 8388607, -8388608, 0, 0, 8388607, -8388608);
      send_coords(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                  8388607, 8388607, 8388607);
      send_coords(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                  -8388608, -8388608, -8388608);
      send_coords(0, 0, 0, 1, 0, 0, -8388608, 8388607, 1);
      send_coords(1, 2, 3, 3, 1, 2, 2, 3, 1);
      send_coords(-1, -1, -1, 1, 1, 1, -1, 1, -1);

      for (k = 0; k < 1050; k++) begin
         mode = $urandom_range(0, 9);
         if (mode < 5) begin
            r = {rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                 rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                 rand_coord(0)};
         end else if (mode < 8) begin
            r = {rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                 rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                 rand_coord(1)};
         end else if (mode == 8) begin
            r = {rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2),
                 rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2),
                 rand_coord(2)};
         end else begin
            // collinear points
            s = $urandom_range(0, 3);
            r.v1_x = rand_coord(1);
            r.v1_y = rand_coord(1);
            r.v1_z = rand_coord(1);
            r.v2_x = r.v1_x + rand_coord(1);
            r.v2_y = r.v1_y + rand_coord(1);
            r.v2_z = r.v1_z + rand_coord(1);
            r.v3_x = COORD_W'(r.v2_x + s * (r.v2_x - r.v1_x));
            r.v3_y = COORD_W'(r.v2_y + s * (r.v2_y - r.v1_y));
            r.v3_z = COORD_W'(r.v2_z + s * (r.v2_z - r.v1_z));
         end
         send_triangle(r);
      end

      start    = 1'b0;
      req_data = '0;
      while (sb.pending_normals.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
